FILE: hw/rtl/shw_pkg.sv
// Shared types, constants and small arithmetic helpers of the shallow water stencil core.
// Used by shallow_water_rhs_stencil_core; depends on nothing else.
`default_nettype none

package shw_pkg;

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_COLS  = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int CELL_W     = 96;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [6:0]  ROWS_RESET   = 7'd64;
    localparam logic [6:0]  COLS_RESET   = 7'd64;
    localparam longint      HALF_G_Q16   = 321388;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        CFG_ROWS   = 3'd0,
        CFG_COLS   = 3'd1,
        CFG_INV_DX = 3'd2,
        CFG_INV_DY = 3'd3,
        CFG_HALF_G = 3'd4
    } t_cfg_idx;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_AVG  = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_POST = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FLUX = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // Operation sequence: eight quotients, four pressure terms, three derivatives.
    localparam logic [3:0] OP_P_FIRST = 4'd8;
    localparam logic [3:0] OP_P_LAST  = 4'd11;
    localparam logic [3:0] OP_D_FIRST = 4'd12;
    localparam logic [3:0] OP_LAST    = 4'd14;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [65:0] S66_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S66_MIN = -66'sd2147483648;

    // Returns {overflow, saturated value}.
    function automatic logic [32:0] sat32(input logic signed [65:0] x);
        logic [32:0] res;
        if (x > S66_MAX) begin
            res = {1'b1, S32_MAX};
        end else if (x < S66_MIN) begin
            res = {1'b1, S32_MIN};
        end else begin
            res = {1'b0, x[31:0]};
        end
        return res;
    endfunction

    // Floor of the mean of two words; always fits 32 bits.
    function automatic logic signed [31:0] avg32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        s = a + b;
        return s[32:1];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/shw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used by the stencil core for its cell memory.
`default_nettype none

module shw_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/shallow_water_rhs_stencil_core.sv
// Shallow water right-hand side core: a cell grid memory plus a sequencer that evaluates
// the five-point stencil with one shared multiplier and one shift-subtract divider.
// Depends on shw_pkg and shw_ram.
//
// A write word stores one cell as it is taken. A read word first fetches the cell and its
// four neighbors from the one read port of the cell memory, then runs eight face quotients
// each through a 64-step restoring divider (skipped when the face depth is zero), and then
// evaluates four pressure terms and three derivatives on the shared multiplier. One word is
// in work at a time; a finished result sits in the output register while the next word is
// taken. Cells are undefined until written, and reads must only touch written cells.
`default_nettype none

module shallow_water_rhs_stencil_core
    import shw_pkg::*;
#(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_in_kind,
    input  wire logic [5:0]            i_in_row,
    input  wire logic [5:0]            i_in_col,
    input  wire logic signed [31:0]    i_in_depth,
    input  wire logic signed [31:0]    i_in_mom_x,
    input  wire logic signed [31:0]    i_in_mom_y,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [31:0]         o_out_d_depth,
    output logic signed [31:0]         o_out_d_mom_x,
    output logic signed [31:0]         o_out_d_mom_y,
    output logic                       o_out_fault
);

    localparam int RCW   = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int CCW   = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CFG_DATA_W-1:0] ONE_RESET = CFG_DATA_W'(64'd1 << FRAC_BITS);
    localparam longint HG_SCALED = (FRAC_BITS >= 16) ? (HALF_G_Q16 << (FRAC_BITS - 16))
                                                     : (HALF_G_Q16 >> (16 - FRAC_BITS));
    localparam logic [CFG_DATA_W-1:0] HG_RESET = CFG_DATA_W'(HG_SCALED);

    // Configuration registers.
    logic [6:0]            r_rows, r_cols;
    logic [CFG_DATA_W-1:0] r_inv_dx, r_inv_dy, r_half_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= ROWS_RESET;
            r_cols   <= COLS_RESET;
            r_inv_dx <= ONE_RESET;
            r_inv_dy <= ONE_RESET;
            r_half_g <= HG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS:   r_rows   <= i_cfg_data[6:0];
                CFG_COLS:   r_cols   <= i_cfg_data[6:0];
                CFG_INV_DX: r_inv_dx <= i_cfg_data;
                CFG_INV_DY: r_inv_dy <= i_cfg_data;
                CFG_HALF_G: r_half_g <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state;
    logic   in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Index clamping of an incoming word.
    logic [RCW-1:0] rows_ext, m_rows, row_ext, row_c, row_i;
    logic [CCW-1:0] cols_ext, n_cols, col_ext, col_c, col_j;
    logic           wr_ok;

    always_comb begin
        rows_ext = RCW'(r_rows);
        cols_ext = CCW'(r_cols);
        row_ext  = RCW'(i_in_row);
        col_ext  = CCW'(i_in_col);
        if (rows_ext < RCW'(3)) begin
            m_rows = RCW'(3);
        end else if (rows_ext > RCW'(MAX_ROWS)) begin
            m_rows = RCW'(MAX_ROWS);
        end else begin
            m_rows = rows_ext;
        end
        if (cols_ext < CCW'(3)) begin
            n_cols = CCW'(3);
        end else if (cols_ext > CCW'(MAX_COLS)) begin
            n_cols = CCW'(MAX_COLS);
        end else begin
            n_cols = cols_ext;
        end
        row_c = (row_ext > m_rows - RCW'(1)) ? m_rows - RCW'(1) : row_ext;
        col_c = (col_ext > n_cols - CCW'(1)) ? n_cols - CCW'(1) : col_ext;
        if (row_c < RCW'(1)) begin
            row_i = RCW'(1);
        end else if (row_c > m_rows - RCW'(2)) begin
            row_i = m_rows - RCW'(2);
        end else begin
            row_i = row_c;
        end
        if (col_c < CCW'(1)) begin
            col_j = CCW'(1);
        end else if (col_c > n_cols - CCW'(2)) begin
            col_j = n_cols - CCW'(2);
        end else begin
            col_j = col_c;
        end
        wr_ok = (row_ext < RCW'(MAX_ROWS)) && (col_ext < CCW'(MAX_COLS));
    end

    // Cell memory: {depth, mom_x, mom_y}.
    logic [RCW-1:0]    r_i, rd_r;
    logic [CCW-1:0]    r_j, rd_c;
    logic [2:0]        r_cnt;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    assign ram_we    = in_acc && (i_in_kind == KIND_WRITE) && wr_ok;
    assign ram_waddr = AW'(row_ext * MAX_COLS + col_ext);

    always_comb begin
        rd_r = r_i;
        rd_c = r_j;
        case (r_cnt)
            3'd1:    rd_r = r_i + RCW'(1);
            3'd2:    rd_r = r_i - RCW'(1);
            3'd3:    rd_c = r_j + CCW'(1);
            3'd4:    rd_c = r_j - CCW'(1);
            default: ;
        endcase
    end

    assign ram_raddr = AW'(rd_r * MAX_COLS + rd_c);

    shw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_in_depth, i_in_mom_x, i_in_mom_y}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Working registers. Cells: center, east, west, north, south.
    // Faces: east, west, north, south.
    logic [CELL_W-1:0]     r_cell [5];
    logic signed [31:0]    r_ah [4], r_au [4], r_av [4];
    logic signed [31:0]    r_q [8], r_p [4], r_fl [4], r_d [3];
    logic [3:0]            r_op;
    logic                  r_ph, r_flt, r_negu, r_negv;
    logic signed [63:0]    r_prod, r_tx;
    logic [31:0]           r_sq;
    logic [63:0]           r_num;
    logic [31:0]           r_rem, r_den;
    logic                  r_neg;
    logic [5:0]            r_dcnt;
    logic                  r_ovld;

    logic [1:0]            face;
    logic signed [33:0]    ma, mb;
    logic signed [67:0]    mprod;
    logic signed [32:0]    dfx, dfy;

    assign face = r_op[1:0];

    always_comb begin
        case (r_op)
            OP_D_FIRST: begin
                dfx = r_au[0] - r_au[1];
                dfy = r_av[2] - r_av[3];
            end
            OP_LAST: begin
                dfx = r_q[4] - r_q[5];
                dfy = r_fl[2] - r_fl[3];
            end
            default: begin
                dfx = r_fl[0] - r_fl[1];
                dfy = r_q[2] - r_q[3];
            end
        endcase
        if (r_op < OP_P_FIRST) begin
            ma = (face < 2'd2) ? r_au[face] : r_av[face];
            mb = (r_op < 4'd4) ? r_au[face] : r_av[face];
        end else if (r_op < OP_D_FIRST) begin
            ma = r_ph ? $signed({2'b00, r_sq}) : 34'(r_ah[face]);
            mb = r_ph ? $signed({3'b000, r_half_g}) : 34'(r_ah[face]);
        end else begin
            ma = r_ph ? 34'(dfy) : 34'(dfx);
            mb = r_ph ? $signed({3'b000, r_inv_dy}) : $signed({3'b000, r_inv_dx});
        end
    end

    assign mprod = ma * mb;

    // Post-processing and divider datapath.
    logic signed [63:0] pshift;
    logic [63:0]        pmag;
    logic signed [31:0] hsel;
    logic [31:0]        hmag;
    logic [32:0]        rem_sh, rem_nx;
    logic               q_bit;
    logic [63:0]        q_nx;
    logic signed [65:0] qval, dsum;
    logic [32:0]        sat_q, sat_p, sat_d, sat_du, sat_dv;
    logic [32:0]        sat_f0, sat_f1, sat_f2, sat_f3;

    always_comb begin
        pshift = r_prod >>> FRAC_BITS;
        pmag   = r_prod[63] ? 64'(-r_prod) : r_prod;
        hsel   = r_ah[face];
        hmag   = hsel[31] ? 32'(-hsel) : hsel;
        rem_sh = {r_rem, r_num[63]};
        q_bit  = (rem_sh >= {1'b0, r_den});
        rem_nx = q_bit ? rem_sh - {1'b0, r_den} : rem_sh;
        q_nx   = {r_num[62:0], q_bit};
        qval   = r_neg ? -$signed({2'b00, q_nx}) : $signed({2'b00, q_nx});
        dsum   = -(66'(r_tx) + 66'(pshift));
        sat_q  = sat32(qval);
        sat_p  = sat32(66'(pshift));
        sat_d  = sat32(dsum);
        sat_du = sat32(-66'(r_d[1]));
        sat_dv = sat32(-66'(r_d[2]));
        sat_f0 = sat32(66'(r_q[0]) + 66'(r_p[0]));
        sat_f1 = sat32(66'(r_q[1]) + 66'(r_p[1]));
        sat_f2 = sat32(66'(r_q[6]) + 66'(r_p[2]));
        sat_f3 = sat32(66'(r_q[7]) + 66'(r_p[3]));
    end

    logic out_take, out_load;
    assign out_take = r_ovld && !i_out_stall;
    assign out_load = (r_state == S_DONE) && (!r_ovld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_cnt   <= '0;
            r_op    <= '0;
            r_ph    <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            if (out_take && !out_load) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in_kind == KIND_READ)) begin
                        r_i     <= row_i;
                        r_j     <= col_j;
                        r_negu  <= (row_c != row_i);
                        r_negv  <= (col_c != col_j);
                        r_flt   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_cnt != 3'd0) begin
                        r_cell[r_cnt - 3'd1] <= ram_rdata;
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd5) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    r_ah[0] <= avg32(r_cell[1][95:64], r_cell[0][95:64]);
                    r_au[0] <= avg32(r_cell[1][63:32], r_cell[0][63:32]);
                    r_av[0] <= avg32(r_cell[1][31:0],  r_cell[0][31:0]);
                    r_ah[1] <= avg32(r_cell[0][95:64], r_cell[2][95:64]);
                    r_au[1] <= avg32(r_cell[0][63:32], r_cell[2][63:32]);
                    r_av[1] <= avg32(r_cell[0][31:0],  r_cell[2][31:0]);
                    r_ah[2] <= avg32(r_cell[3][95:64], r_cell[0][95:64]);
                    r_au[2] <= avg32(r_cell[3][63:32], r_cell[0][63:32]);
                    r_av[2] <= avg32(r_cell[3][31:0],  r_cell[0][31:0]);
                    r_ah[3] <= avg32(r_cell[0][95:64], r_cell[4][95:64]);
                    r_au[3] <= avg32(r_cell[0][63:32], r_cell[4][63:32]);
                    r_av[3] <= avg32(r_cell[0][31:0],  r_cell[4][31:0]);
                    r_op    <= '0;
                    r_ph    <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mprod[63:0];
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (r_op < OP_P_FIRST) begin
                        if (hsel == 32'sd0) begin
                            // Zero face depth: saturate toward the numerator's sign.
                            r_q[r_op[2:0]] <= r_prod[63] ? S32_MIN : S32_MAX;
                            r_flt   <= 1'b1;
                            r_op    <= r_op + 4'd1;
                            r_state <= S_MUL;
                        end else begin
                            r_num   <= pmag;
                            r_den   <= hmag;
                            r_rem   <= '0;
                            r_neg   <= r_prod[63] ^ hsel[31];
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end
                    end else if (r_op < OP_D_FIRST) begin
                        if (!r_ph) begin
                            if (pshift > 64'sd2147483647) begin
                                r_sq  <= 32'h7FFF_FFFF;
                                r_flt <= 1'b1;
                            end else begin
                                r_sq  <= pshift[31:0];
                            end
                            r_ph    <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_p[face] <= sat_p[31:0];
                            r_flt     <= r_flt | sat_p[32];
                            r_ph      <= 1'b0;
                            r_op      <= r_op + 4'd1;
                            r_state   <= (r_op == OP_P_LAST) ? S_FLUX : S_MUL;
                        end
                    end else begin
                        if (!r_ph) begin
                            r_tx    <= pshift;
                            r_ph    <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_d[2'(r_op - OP_D_FIRST)] <= sat_d[31:0];
                            r_flt   <= r_flt | sat_d[32];
                            r_ph    <= 1'b0;
                            r_op    <= r_op + 4'd1;
                            r_state <= (r_op == OP_LAST) ? S_DONE : S_MUL;
                        end
                    end
                end
                S_DIV: begin
                    r_num  <= q_nx;
                    r_rem  <= rem_nx[31:0];
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_q[r_op[2:0]] <= sat_q[31:0];
                        r_flt   <= r_flt | sat_q[32];
                        r_op    <= r_op + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_FLUX: begin
                    r_fl[0] <= sat_f0[31:0];
                    r_fl[1] <= sat_f1[31:0];
                    r_fl[2] <= sat_f2[31:0];
                    r_fl[3] <= sat_f3[31:0];
                    r_flt   <= r_flt | sat_f0[32] | sat_f1[32] | sat_f2[32] | sat_f3[32];
                    r_state <= S_MUL;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register; boundary cells mirror the momentum normal to the edge.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_d_depth <= r_d[0];
            o_out_d_mom_x <= r_negu ? sat_du[31:0] : r_d[1];
            o_out_d_mom_y <= r_negv ? sat_dv[31:0] : r_d[2];
            o_out_fault   <= r_flt | (r_negu & sat_du[32]) | (r_negv & sat_dv[32]);
        end
    end

    assign o_out_valid = r_ovld;

    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_kind == KIND_READ)) |=> (r_state == S_READ))
        else $error("read word did not start the neighbor fetch");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_op <= OP_LAST))
        else $error("operation index past end of sequence");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished read");

endmodule

`default_nettype wire
